### hdl/slrl_pkg.sv
// Shared types and constants for the SPI slave register link.
// Holds the address map, status bit positions, op codes and payload structs.
// No dependencies.
package slrl_pkg;

   localparam int unsigned POT_CHANNELS   = 8;
   localparam int unsigned JOYSTICK_PORTS = 2;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned ADDR_W = 7;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CNT_W  = 32;

   localparam logic [TIME_W-1:0] IDLE_LIMIT_RESET = 32'd5000;

   typedef enum logic [2:0] {
      OP_SPI_BYTE   = 3'd0,
      OP_OVERRUN    = 3'd1,
      OP_POST_KEY   = 3'd2,
      OP_POST_MOUSE = 3'd3,
      OP_POST_SIO   = 3'd4
   } op_type;

   localparam logic [ADDR_W-1:0] ADDR_STATUS    = 7'h00;
   localparam logic [ADDR_W-1:0] ADDR_ALLPOT    = 7'h01;
   localparam logic [ADDR_W-1:0] ADDR_SIO_IN    = 7'h02;
   localparam logic [ADDR_W-1:0] ADDR_SIO_STAT  = 7'h03;
   localparam logic [ADDR_W-1:0] ADDR_KEY_CODE  = 7'h04;
   localparam logic [ADDR_W-1:0] ADDR_KEY_STAT  = 7'h05;
   localparam logic [ADDR_W-1:0] ADDR_MOUSE_X   = 7'h06;
   localparam logic [ADDR_W-1:0] ADDR_MOUSE_Y   = 7'h07;
   localparam logic [ADDR_W-1:0] ADDR_MOUSE_BTN = 7'h08;
   localparam logic [ADDR_W-1:0] ADDR_SIO_OUT   = 7'h09;
   localparam logic [ADDR_W-1:0] ADDR_CMD       = 7'h0A;

   // Range bounds kept one bit wider than the address so the end never wraps.
   localparam logic [ADDR_W:0] ADDR_POT_BASE = 8'h10;
   localparam logic [ADDR_W:0] ADDR_POT_END  = 8'(16 + POT_CHANNELS);
   localparam logic [ADDR_W:0] ADDR_JOY_BASE = 8'h20;
   localparam logic [ADDR_W:0] ADDR_JOY_END  = 8'(32 + JOYSTICK_PORTS);

   localparam int unsigned STAT_KEY_BIT   = 0;
   localparam int unsigned STAT_MOUSE_BIT = 1;
   localparam int unsigned STAT_SIO_BIT   = 2;
   localparam int unsigned SIO_TX_PENDING_BIT = 0;

   localparam logic [DATA_W-1:0] MISO_UNMAPPED = 8'hFF;
   localparam logic [DATA_W-1:0] MISO_IDLE     = 8'h00;

   typedef struct packed {
      logic [2:0]               op;
      logic [DATA_W-1:0]        byte_in;
      logic [DATA_W-1:0]        key_status;
      logic signed [DATA_W-1:0] mouse_dx;
      logic signed [DATA_W-1:0] mouse_dy;
      logic [DATA_W-1:0]        mouse_buttons;
      logic [TIME_W-1:0]        timestamp;
      logic [DATA_W-1:0]        external_value;
   } item_type;

   typedef struct packed {
      logic              miso_load;
      logic [DATA_W-1:0] miso_byte;
      logic              phase_now;
      logic              cmd_line_write;
      logic              cmd_line_level;
      logic              doorbell;
      logic [DATA_W-1:0] status_flags;
      logic [CNT_W-1:0]  transaction_count;
      logic [CNT_W-1:0]  resync_count;
   } result_type;

endpackage

### hdl/slrl_if.sv
// Channel interfaces for the SPI slave register link: request, response, csr.
// Depends on slrl_pkg for widths.
interface slrl_req_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         op;
   logic [slrl_pkg::DATA_W-1:0]        byte_in;
   logic [slrl_pkg::DATA_W-1:0]        key_status;
   logic signed [slrl_pkg::DATA_W-1:0] mouse_dx;
   logic signed [slrl_pkg::DATA_W-1:0] mouse_dy;
   logic [slrl_pkg::DATA_W-1:0]        mouse_buttons;
   logic [slrl_pkg::TIME_W-1:0]        timestamp;
   logic [slrl_pkg::DATA_W-1:0]        external_value;

   modport source (output valid, op, byte_in, key_status, mouse_dx, mouse_dy,
                   mouse_buttons, timestamp, external_value, input ready);
   modport sink   (input valid, op, byte_in, key_status, mouse_dx, mouse_dy,
                   mouse_buttons, timestamp, external_value, output ready);
endinterface

interface slrl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        miso_load;
   logic [slrl_pkg::DATA_W-1:0] miso_byte;
   logic                        phase_now;
   logic                        cmd_line_write;
   logic                        cmd_line_level;
   logic                        doorbell;
   logic [slrl_pkg::DATA_W-1:0] status_flags;
   logic [slrl_pkg::CNT_W-1:0]  transaction_count;
   logic [slrl_pkg::CNT_W-1:0]  resync_count;

   modport source (output valid, miso_load, miso_byte, phase_now, cmd_line_write,
                   cmd_line_level, doorbell, status_flags, transaction_count,
                   resync_count, input ready);
   modport sink   (input valid, miso_load, miso_byte, phase_now, cmd_line_write,
                   cmd_line_level, doorbell, status_flags, transaction_count,
                   resync_count, output ready);
endinterface

interface slrl_csr_if;
   logic                        valid;
   logic                        ready;
   logic [slrl_pkg::TIME_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### hdl/slrl_in_stage.sv
// Input register of the SPI slave register link.
// Depends on slrl_pkg and slrl_req_if.
module slrl_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   slrl_req_if.sink                req,
   input  logic                    advance,
   output logic                    item_valid,
   output slrl_pkg::item_type      item
);

   logic               valid_ff, valid_in;
   slrl_pkg::item_type item_ff, item_in;
   logic               take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.op             = req.op;
         item_in.byte_in        = req.byte_in;
         item_in.key_status     = req.key_status;
         item_in.mouse_dx       = req.mouse_dx;
         item_in.mouse_dy       = req.mouse_dy;
         item_in.mouse_buttons  = req.mouse_buttons;
         item_in.timestamp      = req.timestamp;
         item_in.external_value = req.external_value;
      end
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hdl/slrl_core.sv
// Link state, register file and result register of the SPI slave register link.
// Depends on slrl_pkg, slrl_rsp_if and slrl_csr_if.
module slrl_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  slrl_pkg::item_type      item,
   output logic                    advance,
   slrl_rsp_if.source              rsp,
   slrl_csr_if.sink                csr
);

   logic                              phase_ff, phase_in;
   logic [slrl_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic                              rd_ff, rd_in;
   logic [slrl_pkg::TIME_W-1:0]       last_time_ff, last_time_in;
   logic [slrl_pkg::CNT_W-1:0]        trans_ff, trans_in;
   logic [slrl_pkg::CNT_W-1:0]        resync_ff, resync_in;
   logic [slrl_pkg::DATA_W-1:0]       status_ff, status_in;
   logic [slrl_pkg::DATA_W-1:0]       sio_in_ff, sio_in_in;
   logic [slrl_pkg::DATA_W-1:0]       sio_stat_ff, sio_stat_in;
   logic [slrl_pkg::DATA_W-1:0]       key_code_ff, key_code_in;
   logic [slrl_pkg::DATA_W-1:0]       key_stat_ff, key_stat_in;
   logic [slrl_pkg::DATA_W-1:0]       mouse_x_ff, mouse_x_in;
   logic [slrl_pkg::DATA_W-1:0]       mouse_y_ff, mouse_y_in;
   logic [slrl_pkg::DATA_W-1:0]       mouse_btn_ff, mouse_btn_in;
   logic [slrl_pkg::TIME_W-1:0]       idle_limit_ff, idle_limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   slrl_pkg::result_type              result_ff, result_in;

   logic [slrl_pkg::TIME_W-1:0]       gap;
   logic                              timed_out;
   logic [slrl_pkg::ADDR_W-1:0]       cmd_addr;
   logic [slrl_pkg::ADDR_W:0]         cmd_addr_wide;
   logic [slrl_pkg::DATA_W-1:0]       read_data;
   logic                              fire;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign fire    = advance && item_valid;

   assign csr.ready     = 1'b1;
   assign idle_limit_in = (csr.valid) ? csr.data : idle_limit_ff;

   assign gap       = item.timestamp - last_time_ff;
   assign timed_out = gap > idle_limit_ff;

   assign cmd_addr      = item.byte_in[slrl_pkg::ADDR_W-1:0];
   assign cmd_addr_wide = {1'b0, cmd_addr};

   // Register file read for a read command
   always_comb begin
      case (cmd_addr)
         slrl_pkg::ADDR_STATUS:    read_data = status_ff;
         slrl_pkg::ADDR_ALLPOT:    read_data = slrl_pkg::MISO_UNMAPPED;
         slrl_pkg::ADDR_SIO_IN:    read_data = sio_in_ff;
         slrl_pkg::ADDR_SIO_STAT:  read_data = sio_stat_ff;
         slrl_pkg::ADDR_KEY_CODE:  read_data = key_code_ff;
         slrl_pkg::ADDR_KEY_STAT:  read_data = key_stat_ff;
         slrl_pkg::ADDR_MOUSE_X:   read_data = mouse_x_ff;
         slrl_pkg::ADDR_MOUSE_Y:   read_data = mouse_y_ff;
         slrl_pkg::ADDR_MOUSE_BTN: read_data = mouse_btn_ff;
         default: begin
            if ((cmd_addr_wide >= slrl_pkg::ADDR_POT_BASE &&
                 cmd_addr_wide <  slrl_pkg::ADDR_POT_END) ||
                (cmd_addr_wide >= slrl_pkg::ADDR_JOY_BASE &&
                 cmd_addr_wide <  slrl_pkg::ADDR_JOY_END)) begin
               read_data = item.external_value;
            end else begin
               read_data = slrl_pkg::MISO_UNMAPPED;
            end
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      addr_in      = addr_ff;
      rd_in        = rd_ff;
      last_time_in = last_time_ff;
      trans_in     = trans_ff;
      resync_in    = resync_ff;
      status_in    = status_ff;
      sio_in_in    = sio_in_ff;
      sio_stat_in  = sio_stat_ff;
      key_code_in  = key_code_ff;
      key_stat_in  = key_stat_ff;
      mouse_x_in   = mouse_x_ff;
      mouse_y_in   = mouse_y_ff;
      mouse_btn_in = mouse_btn_ff;

      result_in                = '0;
      result_in.miso_byte      = slrl_pkg::MISO_IDLE;

      case (slrl_pkg::op_type'(item.op))
         slrl_pkg::OP_SPI_BYTE: begin
            last_time_in        = item.timestamp;
            result_in.miso_load = 1'b1;
            if (timed_out && phase_ff) begin
               resync_in = resync_ff + 1'b1;
            end
            if (timed_out || !phase_ff) begin
               // command byte: latch read flag and address
               rd_in    = item.byte_in[slrl_pkg::DATA_W-1];
               addr_in  = cmd_addr;
               phase_in = 1'b1;
               if (item.byte_in[slrl_pkg::DATA_W-1]) begin
                  result_in.miso_byte = read_data;
               end
            end else begin
               // data byte: finish the transaction
               phase_in = 1'b0;
               trans_in = trans_ff + 1'b1;
               if (!rd_ff) begin
                  if (addr_ff == slrl_pkg::ADDR_SIO_OUT) begin
                     sio_stat_in[slrl_pkg::SIO_TX_PENDING_BIT] = 1'b1;
                     sio_in_in = item.byte_in;
                  end else if (addr_ff == slrl_pkg::ADDR_CMD) begin
                     result_in.cmd_line_write = 1'b1;
                     result_in.cmd_line_level = !item.byte_in[0];
                  end else if (addr_ff == slrl_pkg::ADDR_STATUS) begin
                     status_in = status_ff & ~item.byte_in;
                  end
               end
            end
         end
         slrl_pkg::OP_OVERRUN: begin
            phase_in  = 1'b0;
            resync_in = resync_ff + 1'b1;
         end
         slrl_pkg::OP_POST_KEY: begin
            key_code_in = item.byte_in;
            key_stat_in = item.key_status;
            status_in[slrl_pkg::STAT_KEY_BIT] = 1'b1;
            result_in.doorbell = 1'b1;
         end
         slrl_pkg::OP_POST_MOUSE: begin
            mouse_x_in   = $unsigned(item.mouse_dx);
            mouse_y_in   = $unsigned(item.mouse_dy);
            mouse_btn_in = item.mouse_buttons;
            status_in[slrl_pkg::STAT_MOUSE_BIT] = 1'b1;
            result_in.doorbell = 1'b1;
         end
         slrl_pkg::OP_POST_SIO: begin
            sio_in_in = item.byte_in;
            status_in[slrl_pkg::STAT_SIO_BIT] = 1'b1;
            result_in.doorbell = 1'b1;
         end
         default: begin
         end
      endcase

      result_in.phase_now         = phase_in;
      result_in.status_flags      = status_in;
      result_in.transaction_count = trans_in;
      result_in.resync_count      = resync_in;

      if (advance) begin
         rsp_valid_in = item_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         addr_ff       <= '0;
         rd_ff         <= 1'b0;
         last_time_ff  <= '0;
         trans_ff      <= '0;
         resync_ff     <= '0;
         status_ff     <= '0;
         sio_in_ff     <= '0;
         sio_stat_ff   <= '0;
         key_code_ff   <= '0;
         key_stat_ff   <= '0;
         mouse_x_ff    <= '0;
         mouse_y_ff    <= '0;
         mouse_btn_ff  <= '0;
         idle_limit_ff <= slrl_pkg::IDLE_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idle_limit_ff <= idle_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (fire) begin
            phase_ff     <= phase_in;
            addr_ff      <= addr_in;
            rd_ff        <= rd_in;
            last_time_ff <= last_time_in;
            trans_ff     <= trans_in;
            resync_ff    <= resync_in;
            status_ff    <= status_in;
            sio_in_ff    <= sio_in_in;
            sio_stat_ff  <= sio_stat_in;
            key_code_ff  <= key_code_in;
            key_stat_ff  <= key_stat_in;
            mouse_x_ff   <= mouse_x_in;
            mouse_y_ff   <= mouse_y_in;
            mouse_btn_ff <= mouse_btn_in;
         end
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.miso_load         = result_ff.miso_load;
   assign rsp.miso_byte         = result_ff.miso_byte;
   assign rsp.phase_now         = result_ff.phase_now;
   assign rsp.cmd_line_write    = result_ff.cmd_line_write;
   assign rsp.cmd_line_level    = result_ff.cmd_line_level;
   assign rsp.doorbell          = result_ff.doorbell;
   assign rsp.status_flags      = result_ff.status_flags;
   assign rsp.transaction_count = result_ff.transaction_count;
   assign rsp.resync_count      = result_ff.resync_count;

endmodule

### hdl/spi_slave_register_link_unit.sv
// Path: a transaction accepted on req_if passes the input register, then the result
//   register, before it is valid on rsp_if; backpressure can hold it between them.
// Throughput: one transaction per cycle while rsp_if is ready; an input register and a
//   result register with combinational update logic between them set that figure.
// Backpressure on rsp_if holds the result register; the input register still
//   takes one more transaction while the result waits.
// Reset (synchronous, active high): command phase, all counters and registers
//   zero, idle limit 5000 ticks, both channels empty.
module spi_slave_register_link_unit (
   input  logic       clock,
   input  logic       reset,
   slrl_req_if.sink   req_if,
   slrl_rsp_if.source rsp_if,
   slrl_csr_if.sink   csr_if
);

   slrl_pkg::item_type item;
   logic               item_valid;
   logic               advance;

   // Capture each request transaction; release it when the core advances.
   slrl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode the op, update the link state and register file, and load the
   // result register. The core also holds the idle limit written over csr_if.
   slrl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp        (rsp_if),
      .csr        (csr_if)
   );

`ifndef SYNTHESIS
   // A producer event never loads MISO in the same transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.doorbell && rsp_if.miso_load))
      else $error("doorbell and miso_load together");

   // Driving the command line only happens on a data byte, which loads MISO with 0.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.cmd_line_write) |->
         (rsp_if.miso_load && rsp_if.miso_byte == slrl_pkg::MISO_IDLE &&
          !rsp_if.phase_now))
      else $error("command line write outside a write data byte");

   // A result that loads nothing carries an idle MISO byte and no command line write.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.miso_load) |->
         (rsp_if.miso_byte == slrl_pkg::MISO_IDLE && !rsp_if.cmd_line_write))
      else $error("MISO byte present without load");
`endif

endmodule

### verif/tb_spi_slave_register_link_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for spi_slave_register_link_unit: directed script, then random traffic.
// Depends on slrl_pkg, the slrl channel interfaces and the unit itself.
module tb_spi_slave_register_link_unit;

   // Run limits and stimulus shape.
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS     = 310;
   localparam int unsigned DRAIN_CYCLES    = 4;
   localparam logic [slrl_pkg::TIME_W-1:0] SHORT_GAP_MAX = 32'd3000;

   // Op codes that the block must leave without effect.
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // The all-pot register reads every pot as released.
   localparam logic [slrl_pkg::DATA_W-1:0] ALL_POTS_IDLE = 8'hFF;

   localparam slrl_pkg::result_type NO_ANSWER = '0;

   typedef logic [slrl_pkg::ADDR_W-1:0] addr_type;

   // One row of the directed script; answer is only used when known is set.
   typedef struct {
      slrl_pkg::item_type   stim;
      bit                   known;
      slrl_pkg::result_type answer;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slrl_req_if req_if ();
   slrl_rsp_if rsp_if ();
   slrl_csr_if csr_if ();

   spi_slave_register_link_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // 4 ns period: 2 ns high, 2 ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the link state, advanced once per accepted request.
   logic                          link_phase;
   logic [slrl_pkg::ADDR_W-1:0]   link_address;
   logic                          link_read;
   logic [slrl_pkg::TIME_W-1:0]   last_byte_time;
   logic [slrl_pkg::CNT_W-1:0]    txn_total;
   logic [slrl_pkg::CNT_W-1:0]    resync_total;
   logic [slrl_pkg::DATA_W-1:0]   status_bits;
   logic [slrl_pkg::DATA_W-1:0]   sio_in;
   logic [slrl_pkg::DATA_W-1:0]   sio_stat;
   logic [slrl_pkg::DATA_W-1:0]   key_code;
   logic [slrl_pkg::DATA_W-1:0]   key_stat;
   logic [slrl_pkg::DATA_W-1:0]   mouse_x;
   logic [slrl_pkg::DATA_W-1:0]   mouse_y;
   logic [slrl_pkg::DATA_W-1:0]   mouse_btn;
   logic [slrl_pkg::TIME_W-1:0]   idle_limit_now;

   // Responses owed by the block, oldest first.
   slrl_pkg::result_type link_responses[$];

   // Tick count, advanced by a random gap for each generated SPI byte and used to stamp it.
   logic [slrl_pkg::TIME_W-1:0] tick_now;

   bit          idling_on   = 1'b0;
   bit          hold_off_go = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // Byte the slave would load on MISO for a read of register a.
   function automatic logic [slrl_pkg::DATA_W-1:0] register_readback(
         input logic [slrl_pkg::ADDR_W-1:0] a,
         input logic [slrl_pkg::DATA_W-1:0] ext);
      logic [slrl_pkg::ADDR_W:0] wide;
      wide = {1'b0, a};
      case (a)
         slrl_pkg::ADDR_STATUS:    return status_bits;
         slrl_pkg::ADDR_ALLPOT:    return ALL_POTS_IDLE;
         slrl_pkg::ADDR_SIO_IN:    return sio_in;
         slrl_pkg::ADDR_SIO_STAT:  return sio_stat;
         slrl_pkg::ADDR_KEY_CODE:  return key_code;
         slrl_pkg::ADDR_KEY_STAT:  return key_stat;
         slrl_pkg::ADDR_MOUSE_X:   return mouse_x;
         slrl_pkg::ADDR_MOUSE_Y:   return mouse_y;
         slrl_pkg::ADDR_MOUSE_BTN: return mouse_btn;
         default: ;
      endcase
      // Pot and joystick channels both return the externally supplied value.
      if (wide >= slrl_pkg::ADDR_POT_BASE && wide < slrl_pkg::ADDR_POT_END) return ext;
      if (wide >= slrl_pkg::ADDR_JOY_BASE && wide < slrl_pkg::ADDR_JOY_END) return ext;
      return slrl_pkg::MISO_UNMAPPED;
   endfunction

   // Advance the shadow state by one request and return the response it causes.
   function automatic slrl_pkg::result_type register_link_step(
         input slrl_pkg::item_type it);
      slrl_pkg::result_type        r;
      logic [slrl_pkg::TIME_W-1:0] gap;
      r = '0;
      case (it.op)
         slrl_pkg::OP_SPI_BYTE: begin
            // A long quiet gap means the master restarted: treat the byte as a command.
            gap = it.timestamp - last_byte_time;
            if (gap > idle_limit_now) begin
               if (link_phase) resync_total++;
               link_phase = 1'b0;
            end
            last_byte_time = it.timestamp;
            r.miso_load = 1'b1;
            if (!link_phase) begin
               link_read    = it.byte_in[7];
               link_address = it.byte_in[slrl_pkg::ADDR_W-1:0];
               r.miso_byte  = link_read ? register_readback(link_address, it.external_value)
                                        : slrl_pkg::MISO_IDLE;
               link_phase   = 1'b1;
            end else begin
               // Data byte: only the three writable registers react; the rest drop it.
               if (!link_read) begin
                  if (link_address == slrl_pkg::ADDR_SIO_OUT) begin
                     sio_stat[slrl_pkg::SIO_TX_PENDING_BIT] = 1'b1;
                     sio_in = it.byte_in;
                  end else if (link_address == slrl_pkg::ADDR_CMD) begin
                     r.cmd_line_write = 1'b1;
                     r.cmd_line_level = ~it.byte_in[0];
                  end else if (link_address == slrl_pkg::ADDR_STATUS) begin
                     status_bits = status_bits & ~it.byte_in;
                  end
               end
               r.miso_byte = slrl_pkg::MISO_IDLE;
               link_phase  = 1'b0;
               txn_total++;
            end
         end
         slrl_pkg::OP_OVERRUN: begin
            link_phase = 1'b0;
            resync_total++;
         end
         slrl_pkg::OP_POST_KEY: begin
            key_code = it.byte_in;
            key_stat = it.key_status;
            status_bits[slrl_pkg::STAT_KEY_BIT] = 1'b1;
            r.doorbell = 1'b1;
         end
         slrl_pkg::OP_POST_MOUSE: begin
            mouse_x   = it.mouse_dx;
            mouse_y   = it.mouse_dy;
            mouse_btn = it.mouse_buttons;
            status_bits[slrl_pkg::STAT_MOUSE_BIT] = 1'b1;
            r.doorbell = 1'b1;
         end
         slrl_pkg::OP_POST_SIO: begin
            sio_in = it.byte_in;
            status_bits[slrl_pkg::STAT_SIO_BIT] = 1'b1;
            r.doorbell = 1'b1;
         end
         default: ;
      endcase
      r.phase_now         = link_phase;
      r.status_flags      = status_bits;
      r.transaction_count = txn_total;
      r.resync_count      = resync_total;
      return r;
   endfunction

   function automatic script_row_type script_row(
         input logic [2:0] op,
         input logic [slrl_pkg::DATA_W-1:0] data,
         input logic [slrl_pkg::TIME_W-1:0] stamp,
         input logic [slrl_pkg::DATA_W-1:0] ext,
         input bit known,
         input slrl_pkg::result_type answer);
      script_row_type row;
      row.stim.op             = op;
      row.stim.byte_in        = data;
      row.stim.key_status     = 8'hFF;
      row.stim.mouse_dx       = 8'h80;
      row.stim.mouse_dy       = 8'h7F;
      row.stim.mouse_buttons  = 8'hFF;
      row.stim.timestamp      = stamp;
      row.stim.external_value = ext;
      row.known               = known;
      row.answer              = answer;
      return row;
   endfunction

   // Register address for a command byte: mapped registers, channel ranges, their edges and random addresses.
   function automatic addr_type register_pick();
      case ($urandom_range(0, 5))
         0, 1: return addr_type'($urandom_range(slrl_pkg::ADDR_STATUS, slrl_pkg::ADDR_CMD));
         2:    return addr_type'(slrl_pkg::ADDR_POT_BASE +
                                 $urandom_range(0, slrl_pkg::POT_CHANNELS - 1));
         3:    return addr_type'(slrl_pkg::ADDR_JOY_BASE +
                                 $urandom_range(0, slrl_pkg::JOYSTICK_PORTS - 1));
         4: begin
            case ($urandom_range(0, 3))
               0:       return addr_type'(slrl_pkg::ADDR_POT_BASE - 1);
               1:       return addr_type'(slrl_pkg::ADDR_POT_END);
               2:       return addr_type'(slrl_pkg::ADDR_JOY_BASE - 1);
               default: return addr_type'(slrl_pkg::ADDR_JOY_END);
            endcase
         end
         default: return addr_type'($urandom);
      endcase
   endfunction

   // Mostly well-formed command/data pairs, mixed with producer events,
   // overruns, unused ops and gaps around the idle limit.
   function automatic slrl_pkg::item_type random_link_item();
      slrl_pkg::item_type          it;
      int unsigned                 pick;
      logic [slrl_pkg::TIME_W-1:0] gap;
      logic [slrl_pkg::TIME_W-1:0] span;
      it.byte_in        = 8'($urandom);
      it.key_status     = 8'($urandom);
      it.mouse_dx       = 8'($urandom);
      it.mouse_dy       = 8'($urandom);
      it.mouse_buttons  = 8'($urandom);
      it.timestamp      = $urandom;
      it.external_value = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70)      it.op = slrl_pkg::OP_SPI_BYTE;
      else if (pick < 75) it.op = slrl_pkg::OP_OVERRUN;
      else if (pick < 83) it.op = slrl_pkg::OP_POST_KEY;
      else if (pick < 90) it.op = slrl_pkg::OP_POST_MOUSE;
      else if (pick < 96) it.op = slrl_pkg::OP_POST_SIO;
      else                it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      if (it.op == slrl_pkg::OP_SPI_BYTE) begin
         if (!link_phase) it.byte_in = {1'($urandom_range(0, 1)), register_pick()};
         span = (idle_limit_now > SHORT_GAP_MAX) ? SHORT_GAP_MAX : idle_limit_now;
         case ($urandom_range(0, 19))
            0:       gap = idle_limit_now;
            1:       gap = idle_limit_now + 1;
            2:       gap = $urandom;
            default: gap = $urandom_range(0, span);
         endcase
         tick_now     = tick_now + gap;
         it.timestamp = tick_now;
      end
      return it;
   endfunction

   // Present one request from a falling edge and hold it until the block takes it.
   // Leaves valid high so a following request goes out back to back.
   task automatic offer_item(input slrl_pkg::item_type it, input bit known,
                             input slrl_pkg::result_type answer);
      slrl_pkg::result_type owed;
      req_if.valid          = 1'b1;
      req_if.op             = it.op;
      req_if.byte_in        = it.byte_in;
      req_if.key_status     = it.key_status;
      req_if.mouse_dx       = it.mouse_dx;
      req_if.mouse_dy       = it.mouse_dy;
      req_if.mouse_buttons  = it.mouse_buttons;
      req_if.timestamp      = it.timestamp;
      req_if.external_value = it.external_value;
      do @(posedge clock); while (!req_if.ready);
      owed = register_link_step(it);
      link_responses.push_back(known ? answer : owed);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed response, then let the pipeline drain.
   task automatic settle_link();
      req_if.valid = 1'b0;
      while (link_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idle_limit(input logic [slrl_pkg::TIME_W-1:0] limit);
      settle_link();
      csr_if.valid = 1'b1;
      csr_if.data  = limit;
      do @(posedge clock); while (!csr_if.ready);
      idle_limit_now = limit;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic run_random_phase(input int unsigned count, input bit quiet_tail,
                                   input bit with_hold_off);
      slrl_pkg::item_type it;
      tick_now = $urandom;
      for (int unsigned i = 0; i < count; i++) begin
         // Switch idling on or off in stretches; the final phase runs flat out.
         if (i % 50 == 0) idling_on = !quiet_tail && ($urandom_range(0, 3) != 0);
         if (with_hold_off && i == count / 2) hold_off_go = 1'b1;
         if (idling_on && $urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         it = random_link_item();
         offer_item(it, 1'b0, NO_ANSWER);
      end
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Response side: drive ready from the falling edge, with random stall bursts
   // and one long hold-off so the block backs up into its input.
   initial begin : response_sink
      int unsigned stall_left;
      bit          hold_done;
      stall_left    = 0;
      hold_done     = 1'b0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_done) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (stall_left != 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 8);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Check each accepted response against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (link_responses.size() == 0) begin
            $error("response with nothing owed: miso_byte 0x%0h", rsp_if.miso_byte);
            mismatch_count++;
         end else begin
            slrl_pkg::result_type want;
            want = link_responses.pop_front();
            compare_field("miso_load",         want.miso_load,         rsp_if.miso_load);
            compare_field("miso_byte",         want.miso_byte,         rsp_if.miso_byte);
            compare_field("phase_now",         want.phase_now,         rsp_if.phase_now);
            compare_field("cmd_line_write",    want.cmd_line_write,    rsp_if.cmd_line_write);
            compare_field("cmd_line_level",    want.cmd_line_level,    rsp_if.cmd_line_level);
            compare_field("doorbell",          want.doorbell,          rsp_if.doorbell);
            compare_field("status_flags",      want.status_flags,      rsp_if.status_flags);
            compare_field("transaction_count", want.transaction_count, rsp_if.transaction_count);
            compare_field("resync_count",      want.resync_count,      rsp_if.resync_count);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_spi_slave_register_link_unit: errors");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type              script[$];
      logic [slrl_pkg::TIME_W-1:0] phase_limits[5];

      // Hold every input at a known value from time zero.
      req_if.valid          = 1'b0;
      req_if.op             = slrl_pkg::OP_SPI_BYTE;
      req_if.byte_in        = '0;
      req_if.key_status     = '0;
      req_if.mouse_dx       = '0;
      req_if.mouse_dy       = '0;
      req_if.mouse_buttons  = '0;
      req_if.timestamp      = '0;
      req_if.external_value = '0;
      csr_if.valid          = 1'b0;
      csr_if.data           = '0;

      link_phase     = 1'b0;
      link_address   = '0;
      link_read      = 1'b0;
      last_byte_time = '0;
      txn_total      = '0;
      resync_total   = '0;
      status_bits    = '0;
      sio_in         = '0;
      sio_stat       = '0;
      key_code       = '0;
      key_stat       = '0;
      mouse_x        = '0;
      mouse_y        = '0;
      mouse_btn      = '0;
      idle_limit_now = slrl_pkg::IDLE_LIMIT_RESET;
      tick_now       = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed script, run at the reset idle limit of 5000 ticks.
      // Read status right after reset, then complete the transaction.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h80, 32'd0, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0}));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd10, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 32'd1, 32'd0}));
      // Each producer event sets its status bit and rings the doorbell.
      script.push_back(script_row(slrl_pkg::OP_POST_KEY, 8'hFF, 32'd0, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h01, 32'd1, 32'd0}));
      script.push_back(script_row(slrl_pkg::OP_POST_MOUSE, 8'h00, 32'd0, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h03, 32'd1, 32'd0}));
      script.push_back(script_row(slrl_pkg::OP_POST_SIO, 8'hA5, 32'd0, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h07, 32'd1, 32'd0}));
      // Read back the posted key code.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h84, 32'd20, 8'h00, 1'b1,
         slrl_pkg::result_type'{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h07, 32'd1, 32'd0}));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd30, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Command line write: data bit 0 clear drives the line high.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h0A, 32'd40, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd50, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Clear the key and sio status bits, leave mouse.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd60, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h05, 32'd70, 8'h00, 1'b0,
                                  NO_ANSWER));
      // SIO out write sets the tx-pending bit.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h09, 32'd80, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h3C, 32'd90, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Last pot channel and last joystick port read the external value.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h97, 32'd100, 8'h5A, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd110, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'hA1, 32'd120, 8'hC3, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd130, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Unmapped read returns all ones.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'hFF, 32'd140, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd150, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Write to a read-only register is dropped but still counts.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h05, 32'd160, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h77, 32'd170, 8'h00, 1'b0,
                                  NO_ANSWER));
      // All-pot read, then an overrun in the data phase.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h81, 32'd180, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_OVERRUN, 8'h00, 32'd0, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Command, then a gap one past the limit: the next byte is a command again.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h86, 32'd190, 8'h00, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h83, 32'd5191, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Gap exactly at the limit stays a data byte.
      script.push_back(script_row(slrl_pkg::OP_SPI_BYTE, 8'h00, 32'd10191, 8'h00, 1'b0,
                                  NO_ANSWER));
      // Unused op codes report the state unchanged.
      script.push_back(script_row(OP_UNUSED_LO, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0,
                                  NO_ANSWER));
      script.push_back(script_row(OP_UNUSED_HI, 8'h00, 32'd0, 8'h00, 1'b0, NO_ANSWER));

      idling_on = 1'b1;
      foreach (script[i]) begin
         if ($urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         offer_item(script[i].stim, script[i].known, script[i].answer);
      end

      // Random phases across idle limit settings: zero, maximum, small, random, reset value.
      phase_limits[0] = 32'd0;
      phase_limits[1] = 32'hFFFF_FFFF;
      phase_limits[2] = 32'd37;
      phase_limits[3] = $urandom_range(1, 20000);
      phase_limits[4] = slrl_pkg::IDLE_LIMIT_RESET;
      foreach (phase_limits[p]) begin
         set_idle_limit(phase_limits[p]);
         run_random_phase(PHASE_ITEMS, p == 4, p == 1);
      end

      settle_link();
      if (mismatch_count == 0) begin
         $display("tb_spi_slave_register_link_unit: clean");
      end else begin
         $display("tb_spi_slave_register_link_unit: errors");
      end
      $finish;
   end

endmodule
